FILE: rtl/ppmfg_pkg.sv
// ============================================================================
// PPM frame generator package
// Shared constants, codes and structures of the pulse-position frame generator.
// ============================================================================
package ppmfg_pkg;

    // Number of channel slots held by the generator.
    localparam int CHANNELS = 6;

    // Width of the running channel position; it can hold CHANNELS itself.
    localparam int CHAN_W = $clog2(CHANNELS + 1);
    // Width of an index into the slot width store.
    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // Width used when comparing channel numbers of differing widths.
    localparam int CMP_W  = (CHAN_W > 3) ? CHAN_W : 3;

    // Fixed field widths.
    localparam int TICK_W     = 16;
    localparam int CH_FIELD_W = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values.
    localparam logic [CH_FIELD_W-1:0] ACTIVE_RESET = 3'd6;
    localparam logic [TICK_W-1:0]     FRAME_RESET  = 16'd2000;
    localparam logic [TICK_W-1:0]     MARK_RESET   = 16'd50;
    localparam logic [TICK_W-1:0]     WIDTH_RESET  = 16'd100;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_CHANNELS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_TICKS     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MARK_TICKS      = 2'd2;

    // Item operation codes.
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // One input item.
    typedef struct packed {
        t_op                   op;
        logic [CH_FIELD_W-1:0] channel_index;
        logic [TICK_W-1:0]     width_ticks;
    } t_item;

    // Configuration register contents.
    typedef struct packed {
        logic [CH_FIELD_W-1:0] active_channels;
        logic [TICK_W-1:0]     frame_ticks;
        logic [TICK_W-1:0]     mark_ticks;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic                  pin_level;
        logic [CH_FIELD_W-1:0] current_channel;
        logic                  frame_start;
    } t_result;

endpackage

FILE: rtl/ppmfg_cfg_regs.sv
// ============================================================================
// PPM frame generator configuration registers
// Holds the channel count, frame period and mark time written over the port.
// ============================================================================
module ppmfg_cfg_regs
    import ppmfg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register write decode; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_channels <= ACTIVE_RESET;
            r_cfg.frame_ticks     <= FRAME_RESET;
            r_cfg.mark_ticks      <= MARK_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_ACTIVE_CHANNELS: r_cfg.active_channels <= i_cfg_wdata[CH_FIELD_W-1:0];
                CFG_FRAME_TICKS:     r_cfg.frame_ticks     <= i_cfg_wdata[TICK_W-1:0];
                CFG_MARK_TICKS:      r_cfg.mark_ticks      <= i_cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/ppmfg_slot_engine.sv
// ============================================================================
// PPM frame generator slot engine
// Tick counter, slot timing and channel width store, updated once per item.
// ============================================================================
module ppmfg_slot_engine
    import ppmfg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] r_slot_start;
    logic [CHAN_W-1:0] r_chan;
    logic              r_pin;
    logic [TICK_W-1:0] r_widths [CHANNELS];

    logic [TICK_W-1:0] n_tick;
    logic [TICK_W-1:0] n_slot_start;
    logic [CHAN_W-1:0] n_chan;
    logic              n_pin;
    logic              n_started;

    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] width_sel;
    logic [TICK_W:0]   mark_sum;
    logic [TICK_W:0]   width_sum;
    logic              chan_live;
    logic              wr_ok;

    // Width of the slot now being timed; a position past the store reads zero.
    always_comb begin
        if (CMP_W'(r_chan) < CMP_W'(CHANNELS)) begin
            width_sel = r_widths[IDX_W'(r_chan)];
        end else begin
            width_sel = '0;
        end
    end

    // Slot end points, formed one bit wider so that they never wrap.
    assign tick_inc  = r_tick + TICK_W'(1);
    assign mark_sum  = {1'b0, r_slot_start} + {1'b0, i_cfg.mark_ticks};
    assign width_sum = {1'b0, r_slot_start} + {1'b0, width_sel};

    // Channels remain while the position is below both the active count and the store size.
    assign chan_live = (CMP_W'(r_chan) < CMP_W'(i_cfg.active_channels)) &&
                       (CMP_W'(r_chan) < CMP_W'(CHANNELS));

    // Width writes outside the store are dropped.
    assign wr_ok = CMP_W'(i_item.channel_index) < CMP_W'(CHANNELS);

    // Next state for a tick: frame restart, end of mark, or start of next slot.
    always_comb begin
        n_tick       = r_tick;
        n_slot_start = r_slot_start;
        n_chan       = r_chan;
        n_pin        = r_pin;
        n_started    = 1'b0;
        if (i_item.op == OP_TICK) begin
            n_tick = tick_inc;
            if (tick_inc == i_cfg.frame_ticks) begin
                n_tick       = '0;
                n_slot_start = '0;
                n_chan       = '0;
                n_pin        = 1'b1;
                n_started    = 1'b1;
            end else if ({1'b0, tick_inc} == mark_sum) begin
                n_pin = 1'b0;
            end else if (chan_live && ({1'b0, tick_inc} == width_sum)) begin
                n_pin        = 1'b1;
                n_chan       = r_chan + CHAN_W'(1);
                n_slot_start = tick_inc;
            end
        end
    end

    // Timing state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_slot_start <= '0;
            r_chan       <= '0;
            r_pin        <= 1'b0;
        end else if (i_step) begin
            r_tick       <= n_tick;
            r_slot_start <= n_slot_start;
            r_chan       <= n_chan;
            r_pin        <= n_pin;
        end
    end

    // Channel width store, preset to the default width at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_widths[k] <= WIDTH_RESET;
            end
        end else if (i_step && (i_item.op == OP_WRITE) && wr_ok) begin
            r_widths[IDX_W'(i_item.channel_index)] <= i_item.width_ticks;
        end
    end

    // Result reflects the state after this item.
    assign o_result.pin_level       = n_pin;
    assign o_result.current_channel = CH_FIELD_W'(n_chan);
    assign o_result.frame_start     = n_started;

endmodule

FILE: rtl/ppm_frame_generator.sv
// ============================================================================
// PPM frame generator
// Builds a multi-channel pulse-position frame from timer tick transfers.
// ============================================================================
// Usage:
//   Each transfer on the s_axis side is one item: tuser 0 is a timer tick,
//   tuser 1 writes a channel width (index and width in tdata). Every item
//   gives exactly one transfer on the m_axis side carrying the pin level and
//   the channel being timed, with tuser flagging a tick that began a frame.
//   Items pass through an input register, the slot engine and a result
//   register: a result is offered once its item has moved on from the input
//   register, and one item is taken every cycle while the receiver keeps up,
//   as the tick counter and slot registers update for each item. When the
//   receiver stalls, the result register holds its transfer and the input
//   register holds one more item; s_axis_tready then falls until the result
//   is taken. Configuration writes take effect on the following edge; the
//   user makes them while no item is in flight; the block does not enforce
//   this. Reset clears the counters, sets the pin low, presets every
//   channel width to 100 ticks and loads the default channel count, frame
//   period and mark time; both sides come out empty.
// ============================================================================
module ppm_frame_generator
    import ppmfg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Item stream in.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // channel_index[2:0], width_ticks[18:3]
    input  logic                  s_axis_tuser,  // operation[0]
    // Result stream out.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // pin_level[0], current_channel[3:1]
    output logic                  m_axis_tuser   // frame_start[0]
);

    t_cfg    cfg;
    t_result eng_result;
    logic    advance;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    ppmfg_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // The held item moves on when the result register is free or being emptied.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.op            <= t_op'(s_axis_tuser);
            r_in_item.channel_index <= s_axis_tdata[2:0];
            r_in_item.width_ticks   <= s_axis_tdata[18:3];
        end
    end

    ppmfg_slot_engine u_slot_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (eng_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= eng_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.current_channel, r_out.pin_level};
    assign m_axis_tuser  = r_out.frame_start;

`ifndef SYNTHESIS
    // A frame start always shows the pin high on the first channel.
    a_frame_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[0] && (m_axis_tdata[3:1] == 3'd0)))
        else $error("frame start without pin high on channel zero");

    // A width write never begins a frame.
    a_write_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_item.op == OP_WRITE)) |=> !m_axis_tuser)
        else $error("width write flagged as frame start");

    // The result register is loaded whenever an item leaves the input register.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> m_axis_tvalid)
        else $error("item processed without a result");
`endif

endmodule
